### rtl/rxs_pkg.sv
// Shared types, constants and the sequencer microcode for the record exchange sorter.
// Used by rxs_sequencer, rxs_datapath and record_exchange_sort_by_key; depends on nothing.
`default_nettype none

package rxs_pkg;

  // Default capacity of the record store.
  localparam int MAX_RECORDS_DEF = 64;

  // Input item: one record, plus the mark that closes the set.
  typedef struct packed {
    logic [15:0] hours_key;
    logic [11:0] birth_year;
    logic [7:0]  record_tag;
    logic        last_record;
  } rec_in_t;

  // Result item: one sorted record with run status.
  typedef struct packed {
    logic [15:0] out_hours;
    logic [11:0] out_birth_year;
    logic [7:0]  out_tag;
    logic        out_last;
    logic        overflowed;
  } rec_out_t;

  // Stored record as held in the record memory.
  typedef struct packed {
    logic [15:0] hours;
    logic [11:0] year;
    logic [7:0]  tag;
  } rec_t;

  // Microprogram step addresses.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_START = 3'd1,
    ST_OUTER = 3'd2,
    ST_LDCUR = 3'd3,
    ST_INNER = 3'd4,
    ST_EMIT  = 3'd5,
    ST_NEXT  = 3'd6,
    ST_DONE  = 3'd7
  } step_e;

  // Branch conditions tested by the sequencer.
  typedef enum logic [2:0] {
    COND_ALWAYS   = 3'd0,
    COND_ACC_LAST = 3'd1,
    COND_J_LT_N   = 3'd2,
    COND_J1_LT_N  = 3'd3,
    COND_OUT_FREE = 3'd4,
    COND_I1_LT_N  = 3'd5
  } cond_e;

  // One control word of the microprogram.
  typedef struct packed {
    logic  accept;   // take input items and store them
    logic  clr_i;    // outer index to zero
    logic  rd_i;     // read the record at the outer index
    logic  j_init;   // inner index to outer index plus one
    logic  cur_ld;   // load the running record from read data
    logic  cmp;      // compare and swap against the inner record
    logic  j_inc;    // advance the inner index, read ahead
    logic  emit;     // hand the running record to the output register
    logic  i_inc;    // advance the outer index
    logic  clr_set;  // clear count and drop flag for the next set
    cond_e cond;
    step_e t_true;
    step_e t_false;
  } ctrl_t;

  // Status flags from the datapath to the sequencer.
  typedef struct packed {
    logic acc_last;
    logic j_lt_n;
    logic j1_lt_n;
    logic out_free;
    logic i1_lt_n;
  } stat_t;

  // Microcode ROM: one control word per step.
  function automatic ctrl_t ucode_rom(step_e step);
    ctrl_t w;
    w = '0;
    w.cond    = COND_ALWAYS;
    w.t_true  = ST_IDLE;
    w.t_false = ST_IDLE;
    unique case (step)
      ST_IDLE: begin
        w.accept  = 1'b1;
        w.cond    = COND_ACC_LAST;
        w.t_true  = ST_START;
        w.t_false = ST_IDLE;
      end
      ST_START: begin
        w.clr_i   = 1'b1;
        w.t_true  = ST_OUTER;
      end
      ST_OUTER: begin
        w.rd_i    = 1'b1;
        w.j_init  = 1'b1;
        w.t_true  = ST_LDCUR;
      end
      ST_LDCUR: begin
        w.cur_ld  = 1'b1;
        w.cond    = COND_J_LT_N;
        w.t_true  = ST_INNER;
        w.t_false = ST_EMIT;
      end
      ST_INNER: begin
        w.cmp     = 1'b1;
        w.j_inc   = 1'b1;
        w.cond    = COND_J1_LT_N;
        w.t_true  = ST_INNER;
        w.t_false = ST_EMIT;
      end
      ST_EMIT: begin
        w.emit    = 1'b1;
        w.cond    = COND_OUT_FREE;
        w.t_true  = ST_NEXT;
        w.t_false = ST_EMIT;
      end
      ST_NEXT: begin
        w.i_inc   = 1'b1;
        w.cond    = COND_I1_LT_N;
        w.t_true  = ST_OUTER;
        w.t_false = ST_DONE;
      end
      ST_DONE: begin
        w.clr_set = 1'b1;
        w.t_true  = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### rtl/rxs_sequencer.sv
// Microcode sequencer: step register, ROM lookup and conditional branch.
// Depends on rxs_pkg for the control word, status flags and microcode ROM.
`default_nettype none

module rxs_sequencer (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire rxs_pkg::stat_t stat_i,
  output rxs_pkg::ctrl_t     ctrl_o
);
  import rxs_pkg::*;

  step_e upc_q, upc_d;
  logic  cond_ok;

  // Control word of the current step.
  assign ctrl_o = ucode_rom(upc_q);

  // Evaluate the branch condition of the current step.
  always_comb begin
    unique case (ctrl_o.cond)
      COND_ALWAYS:   cond_ok = 1'b1;
      COND_ACC_LAST: cond_ok = stat_i.acc_last;
      COND_J_LT_N:   cond_ok = stat_i.j_lt_n;
      COND_J1_LT_N:  cond_ok = stat_i.j1_lt_n;
      COND_OUT_FREE: cond_ok = stat_i.out_free;
      COND_I1_LT_N:  cond_ok = stat_i.i1_lt_n;
      default:       cond_ok = 1'b1;
    endcase
    upc_d = cond_ok ? ctrl_o.t_true : ctrl_o.t_false;
  end

  // Step register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= ST_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

`default_nettype wire

### rtl/rxs_datapath.sv
// Datapath of the record sorter: record memory, indices, running record and output register.
// Depends on rxs_pkg; steered by the control word from rxs_sequencer.
`default_nettype none

module rxs_datapath #(
  parameter int MAX_RECORDS = rxs_pkg::MAX_RECORDS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire rxs_pkg::ctrl_t   ctrl_i,
  output rxs_pkg::stat_t        stat_o,
  input  wire logic             in_valid_i,
  input  wire rxs_pkg::rec_in_t in_data_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output rxs_pkg::rec_out_t     out_data_o
);
  import rxs_pkg::*;

  localparam int AW  = $clog2(MAX_RECORDS);
  localparam int CW  = $clog2(MAX_RECORDS + 1);
  localparam int CW1 = CW + 1;
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_RECORDS);

  rec_t            mem_q [MAX_RECORDS];
  rec_t            rd_q;
  rec_t            cur_q, cur_d;
  rec_out_t        out_q, out_d;
  logic            out_valid_q, out_valid_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            drop_q, drop_d;
  logic [AW-1:0]   i_q, i_d;
  logic [CW-1:0]   j_q, j_d;

  logic            in_fire;
  logic            has_room;
  logic            swap;
  logic            out_free;
  logic            emit_fire;
  logic [CW1-1:0]  i_nxt, j_nxt, cnt_ext;
  rec_t            in_rec;
  logic            wr_en;
  logic [AW-1:0]   wr_addr, rd_addr;
  rec_t            wr_data;

  // Handshake and compare terms.
  assign in_stall_o = !ctrl_i.accept;
  assign in_fire    = in_valid_i && ctrl_i.accept;
  assign has_room   = cnt_q < MaxCnt;
  assign i_nxt      = CW1'(i_q) + CW1'(1);
  assign j_nxt      = CW1'(j_q) + CW1'(1);
  assign cnt_ext    = CW1'(cnt_q);
  assign swap       = ctrl_i.cmp && (cur_q.hours > rd_q.hours);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit_fire  = ctrl_i.emit && out_free;

  assign in_rec.hours = in_data_i.hours_key;
  assign in_rec.year  = in_data_i.birth_year;
  assign in_rec.tag   = in_data_i.record_tag;

  // Status back to the sequencer.
  assign stat_o.acc_last = in_fire && in_data_i.last_record;
  assign stat_o.j_lt_n   = j_q < cnt_q;
  assign stat_o.j1_lt_n  = j_nxt < cnt_ext;
  assign stat_o.out_free = out_free;
  assign stat_o.i1_lt_n  = i_nxt < cnt_ext;

  // Memory port selection: loading writes at the fill count, a swap writes at the inner index.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_q[AW-1:0];
    wr_data = in_rec;
    if (in_fire && has_room) begin
      wr_en = 1'b1;
    end else if (swap) begin
      wr_en   = 1'b1;
      wr_addr = j_q[AW-1:0];
      wr_data = cur_q;
    end
    if (ctrl_i.rd_i) begin
      rd_addr = i_q;
    end else if (ctrl_i.j_inc) begin
      rd_addr = j_nxt[AW-1:0];
    end else begin
      rd_addr = j_q[AW-1:0];
    end
  end

  // Record memory with registered read data.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[rd_addr];
  end

  // Next values of indices, counters, running record and output register.
  always_comb begin
    cnt_d       = cnt_q;
    drop_d      = drop_q;
    i_d         = i_q;
    j_d         = j_q;
    cur_d       = cur_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    if (ctrl_i.clr_set) begin
      cnt_d  = '0;
      drop_d = 1'b0;
    end else if (in_fire) begin
      if (has_room) begin
        cnt_d = cnt_q + CW'(1);
      end else begin
        drop_d = 1'b1;
      end
    end

    if (ctrl_i.clr_i) begin
      i_d = '0;
    end else if (ctrl_i.i_inc) begin
      i_d = i_nxt[AW-1:0];
    end

    if (ctrl_i.j_init) begin
      j_d = i_nxt[CW-1:0];
    end else if (ctrl_i.j_inc) begin
      j_d = j_nxt[CW-1:0];
    end

    // The running record takes the smaller key on a swap.
    if (ctrl_i.cur_ld || swap) begin
      cur_d = rd_q;
    end

    if (emit_fire) begin
      out_valid_d            = 1'b1;
      out_d.out_hours        = cur_q.hours;
      out_d.out_birth_year   = cur_q.year;
      out_d.out_tag          = cur_q.tag;
      out_d.out_last         = !stat_o.i1_lt_n;
      out_d.overflowed       = drop_q;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      drop_q      <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      drop_q      <= drop_d;
      i_q         <= i_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### rtl/record_exchange_sort_by_key.sv
// Top level of the record exchange sorter: microcode sequencer plus datapath.
// Depends on rxs_pkg, rxs_sequencer and rxs_datapath.
//
// Usage: records enter on the input channel (in_valid_i / in_stall_o / in_data_i), one per
// item, and are stored at one item per cycle while the stall output is low. Up to
// MAX_RECORDS records are kept; further records of the set are dropped and the overflowed
// flag is raised on every result of the run. The item with last_record set closes the set;
// the stall output then rises while the stored records are sorted by ascending hours_key
// (exchange order, so ties follow that procedure) and streamed out on the output channel
// (out_valid_o / out_stall_i / out_data_o), the final result carrying out_last.
// The time for each result is bound by the single compare-and-swap step of the inner loop
// over the one-write-port record memory. After the last result enters the output register,
// the sequencer passes its advance and done steps before the input stall drops.
// A stalled output holds its item and the sequencer waits at the hand-off step.
// Reset clears the fill count, drop flag, output valid and returns to the load step;
// the record memory is not cleared, since only entries written in the current set are used.
`default_nettype none

module record_exchange_sort_by_key #(
  parameter int MAX_RECORDS = rxs_pkg::MAX_RECORDS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire rxs_pkg::rec_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output rxs_pkg::rec_out_t      out_data_o
);
  import rxs_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  // Step sequencer running the microprogram.
  rxs_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  // Record memory, indices and output register.
  rxs_datapath #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

### tb/sort_order_checker.sv
`timescale 1ns / 1ps
// Checker for the record exchange sorter: watches both channels, predicts the sorted runs
// and compares every result item. Depends on rxs_pkg.
module sort_order_checker
  import rxs_pkg::*;
#(
  parameter int CAPACITY = MAX_RECORDS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_stall_i,
  input  rec_in_t  in_data_i,
  input  logic     out_valid_i,
  input  logic     out_stall_i,
  input  rec_out_t out_data_i,
  output int       mismatches_o,
  output int       awaited_o
);

  // Predicted copy of the record store and its set status.
  rec_t        held_recs [CAPACITY];
  int unsigned held_cnt;
  logic        dropped;

  // Sorted records that the block still owes, oldest first.
  rec_out_t    sorted_due_q [$];
  int          mismatches;

  assign mismatches_o = mismatches;
  assign awaited_o    = sorted_due_q.size();

  // Store one record; a marked item sorts the set and queues its run.
  function automatic void absorb_record(rec_in_t item);
    rec_t        swap_rec;
    rec_out_t    res;
    int unsigned i;
    int unsigned j;
    if (held_cnt < CAPACITY) begin
      held_recs[held_cnt] = '{hours: item.hours_key, year: item.birth_year,
                              tag: item.record_tag};
      held_cnt++;
    end else begin
      dropped = 1'b1;
    end
    if (!item.last_record) return;
    // Exchange sort: position i against every later j, swap when i is greater.
    for (i = 0; i < held_cnt; i++) begin
      for (j = i + 1; j < held_cnt; j++) begin
        if (held_recs[i].hours > held_recs[j].hours) begin
          swap_rec     = held_recs[i];
          held_recs[i] = held_recs[j];
          held_recs[j] = swap_rec;
        end
      end
    end
    for (i = 0; i < held_cnt; i++) begin
      res.out_hours      = held_recs[i].hours;
      res.out_birth_year = held_recs[i].year;
      res.out_tag        = held_recs[i].tag;
      res.out_last       = (i + 1 == held_cnt);
      res.overflowed     = dropped;
      sorted_due_q.push_back(res);
    end
    held_cnt = 0;
    dropped  = 1'b0;
  endfunction

  // Compare one result item against the oldest owed record.
  function automatic void match_result(rec_out_t got);
    rec_out_t want;
    if (sorted_due_q.size() == 0) begin
      $error("result item with nothing owed: hours %0d tag %0d", got.out_hours, got.out_tag);
      mismatches++;
      return;
    end
    want = sorted_due_q.pop_front();
    if (got.out_hours !== want.out_hours) begin
      $error("out_hours: expected %0d, actual %0d", want.out_hours, got.out_hours);
      mismatches++;
    end
    if (got.out_birth_year !== want.out_birth_year) begin
      $error("out_birth_year: expected %0d, actual %0d", want.out_birth_year,
             got.out_birth_year);
      mismatches++;
    end
    if (got.out_tag !== want.out_tag) begin
      $error("out_tag: expected %0d, actual %0d", want.out_tag, got.out_tag);
      mismatches++;
    end
    if (got.out_last !== want.out_last) begin
      $error("out_last: expected %0d, actual %0d", want.out_last, got.out_last);
      mismatches++;
    end
    if (got.overflowed !== want.overflowed) begin
      $error("overflowed: expected %0d, actual %0d", want.overflowed, got.overflowed);
      mismatches++;
    end
  endfunction

  // Both channels are sampled at the rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt   <= 0;
      dropped    <= 1'b0;
      mismatches <= 0;
      sorted_due_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) match_result(out_data_i);
      if (in_valid_i && !in_stall_i) absorb_record(in_data_i);
    end
  end

endmodule

### tb/tb_record_exchange_sort_by_key.sv
`timescale 1ns / 1ps
// Testbench top for the record exchange sorter: reset, directed and random record sets,
// random idling on both sides, verdict. Depends on rxs_pkg, the block and sort_order_checker.
module tb_record_exchange_sort_by_key;
  import rxs_pkg::*;

  localparam int CAPACITY     = MAX_RECORDS_DEF;
  localparam int ITEM_TARGET  = 430;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_HOLD    = 300;
  localparam int HOLD_AT      = 30;
  localparam int DRAIN_CYCLES = 60;

  // How the keys of one set are spread.
  typedef enum int {
    KEY_FULL,
    KEY_NARROW,
    KEY_EDGE
  } key_spread_e;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  rec_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  rec_out_t out_data_o;

  int       mismatches;
  int       awaited;
  int       cycle_cnt = 0;
  int       items_sent = 0;
  bit       send_burst = 1'b0;
  bit       take_burst = 1'b0;

  record_exchange_sort_by_key #(
    .MAX_RECORDS(CAPACITY)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  sort_order_checker #(
    .CAPACITY(CAPACITY)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .mismatches_o(mismatches),
    .awaited_o   (awaited)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Offer one record after a random gap and hold it until it is taken.
  task automatic send_record(input rec_in_t item);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_fields(input logic [15:0] key, input logic [11:0] year,
                             input logic [7:0] tag, input logic last);
    rec_in_t item;
    item.hours_key   = key;
    item.birth_year  = year;
    item.record_tag  = tag;
    item.last_record = last;
    send_record(item);
  endtask

  function automatic logic [15:0] pick_key(key_spread_e spread);
    int unsigned pick;
    pick = $urandom_range(0, 2);
    case (spread)
      KEY_NARROW: return 16'($urandom_range(0, 3));
      KEY_EDGE: begin
        if (pick == 0) return 16'h0000;
        if (pick == 1) return 16'hFFFF;
        return 16'($urandom);
      end
      default: return 16'($urandom);
    endcase
  endfunction

  // One set of random records; the final one carries the last mark.
  task automatic send_set(input int count, input key_spread_e spread);
    int k;
    send_burst = ($urandom_range(0, 3) == 0);
    for (k = 0; k < count; k++) begin
      send_fields(pick_key(spread), 12'($urandom), 8'($urandom), k == count - 1);
    end
  endtask

  // Receiver: a random stall before each result, one long hold-off once.
  initial begin
    int  wait_cycles;
    int  taken;
    bit  held_long;
    taken     = 0;
    held_long = 1'b0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 31) == 0) take_burst = !take_burst;
      wait_cycles = take_burst ? 0 : $urandom_range(0, 19);
      if (!held_long && taken == HOLD_AT) begin
        wait_cycles = LONG_HOLD;
        held_long   = 1'b1;
      end
      if (wait_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_cycles) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      taken++;
      @(negedge clk_i);
    end
  end

  // Stimulus and verdict.
  initial begin
    int          set_idx;
    int          pick;
    int          count;
    key_spread_e spread;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Single-record sets at both extremes of every field.
    send_fields(16'hFFFF, 12'hFFF, 8'hFF, 1'b1);
    send_fields(16'h0000, 12'h000, 8'h00, 1'b1);
    // Descending keys, fully reversed by the sort.
    send_fields(16'hFFFF, 12'h000, 8'h00, 1'b0);
    send_fields(16'h8000, 12'hFFF, 8'hFF, 1'b0);
    send_fields(16'h0001, 12'h000, 8'h01, 1'b0);
    send_fields(16'h0000, 12'hFFF, 8'hFE, 1'b1);
    // Repeated keys: the order of equal keys follows the exchange procedure.
    send_fields(16'd7, 12'd1, 8'd1, 1'b0);
    send_fields(16'd3, 12'd2, 8'd2, 1'b0);
    send_fields(16'd7, 12'd3, 8'd3, 1'b0);
    send_fields(16'd3, 12'd4, 8'd4, 1'b0);
    send_fields(16'd7, 12'd5, 8'd5, 1'b1);
    // Alternating bit patterns with a tie.
    send_fields(16'hAAAA, 12'hAAA, 8'hAA, 1'b0);
    send_fields(16'h5555, 12'h555, 8'h55, 1'b0);
    send_fields(16'hAAAA, 12'h555, 8'h5A, 1'b1);

    // Random sets: mostly small, a full store and an overflowing one early on.
    set_idx = 0;
    while (items_sent < ITEM_TARGET) begin
      pick   = $urandom_range(0, 99);
      spread = key_spread_e'($urandom_range(0, 2));
      if (set_idx == 3) count = CAPACITY;
      else if (set_idx == 8) count = CAPACITY + 3;
      else if (pick < 70) count = $urandom_range(1, 8);
      else if (pick < 92) count = $urandom_range(9, 30);
      else if (pick < 96) count = $urandom_range(CAPACITY - 4, CAPACITY);
      else count = $urandom_range(CAPACITY + 1, CAPACITY + 6);
      send_set(count, spread);
      set_idx++;
    end
    in_valid_i <= 1'b0;

    // Drain the owed results, then give stray results time to show.
    while (awaited != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && awaited == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
